>>> design/tcs_pkg.sv
package tcs_pkg;

    // Width of every result field
    localparam int OUT_BITS = 16;

    // One byte of text with its end flag
    typedef struct packed {
        logic [7:0] char_byte;
        logic       text_end;
    } t_tcs_in;

    // Final counts of one text
    typedef struct packed {
        logic [OUT_BITS-1:0] total_chars;
        logic [OUT_BITS-1:0] letter_count;
        logic [OUT_BITS-1:0] upper_count;
        logic [OUT_BITS-1:0] lower_count;
        logic [OUT_BITS-1:0] digit_count;
        logic [OUT_BITS-1:0] space_count;
        logic [OUT_BITS-1:0] other_count;
        logic [OUT_BITS-1:0] word_count;
        logic [OUT_BITS-1:0] longest_word_len;
    } t_tcs_out;

    // Character class flags of one byte, exactly one is set
    typedef struct packed {
        logic is_space;
        logic is_upper;
        logic is_lower;
        logic is_digit;
        logic is_other;
    } t_tcs_class;

    // Byte codes of the class boundaries
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHR_LO_A  = 8'h61;
    localparam logic [7:0] CHR_LO_Z  = 8'h7A;

endpackage

>>> design/tcs_classify.sv
module tcs_classify (
    input  logic [7:0]          i_char_byte,
    output tcs_pkg::t_tcs_class o_class
);

    logic w_space;
    logic w_upper;
    logic w_lower;
    logic w_digit;

    // Class the byte by C-locale rules; high bytes fall into other
    always_comb begin
        w_space = (i_char_byte == tcs_pkg::CHR_SPACE) ||
                  ((i_char_byte >= tcs_pkg::CHR_TAB) && (i_char_byte <= tcs_pkg::CHR_CR));
        w_upper = (i_char_byte >= tcs_pkg::CHR_UP_A) && (i_char_byte <= tcs_pkg::CHR_UP_Z);
        w_lower = (i_char_byte >= tcs_pkg::CHR_LO_A) && (i_char_byte <= tcs_pkg::CHR_LO_Z);
        w_digit = (i_char_byte >= tcs_pkg::CHR_0) && (i_char_byte <= tcs_pkg::CHR_9);
        o_class.is_space = w_space;
        o_class.is_upper = w_upper;
        o_class.is_lower = w_lower;
        o_class.is_digit = w_digit;
        o_class.is_other = !(w_space || w_upper || w_lower || w_digit);
    end

endmodule

>>> design/tcs_counters.sv
module tcs_counters #(
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_last,
    input  tcs_pkg::t_tcs_class i_class,
    output tcs_pkg::t_tcs_out   o_result
);

    localparam int WIDE_BITS = (COUNT_BITS > tcs_pkg::OUT_BITS) ? COUNT_BITS
                                                                 : tcs_pkg::OUT_BITS;

    logic [COUNT_BITS-1:0] r_byte_total;
    logic [COUNT_BITS-1:0] r_letters;
    logic [COUNT_BITS-1:0] r_uppers;
    logic [COUNT_BITS-1:0] r_lowers;
    logic [COUNT_BITS-1:0] r_digits;
    logic [COUNT_BITS-1:0] r_spaces;
    logic [COUNT_BITS-1:0] r_others;
    logic [COUNT_BITS-1:0] r_words;
    logic                  r_inside;
    logic [COUNT_BITS-1:0] r_cur_len;
    logic [COUNT_BITS-1:0] r_best_len;

    logic [COUNT_BITS-1:0] n_byte_total;
    logic [COUNT_BITS-1:0] n_letters;
    logic [COUNT_BITS-1:0] n_uppers;
    logic [COUNT_BITS-1:0] n_lowers;
    logic [COUNT_BITS-1:0] n_digits;
    logic [COUNT_BITS-1:0] n_spaces;
    logic [COUNT_BITS-1:0] n_others;
    logic [COUNT_BITS-1:0] n_words;
    logic                  n_inside;
    logic [COUNT_BITS-1:0] n_cur_len;
    logic [COUNT_BITS-1:0] n_best_len;

    logic                  w_close;
    logic [COUNT_BITS-1:0] w_end_words;
    logic [COUNT_BITS-1:0] w_end_best;

    // Add one unless the counter already sits at its maximum
    function automatic logic [COUNT_BITS-1:0] bump(
        input logic [COUNT_BITS-1:0] value,
        input logic                  en
    );
        logic [COUNT_BITS-1:0] res;
        res = value;
        if (en && !(&value)) begin
            res = value + COUNT_BITS'(1);
        end
        return res;
    endfunction

    // Clip a counter to the result field width
    function automatic logic [tcs_pkg::OUT_BITS-1:0] shown(
        input logic [COUNT_BITS-1:0] value
    );
        logic [WIDE_BITS-1:0] ext;
        ext = WIDE_BITS'(value);
        if (ext > WIDE_BITS'({tcs_pkg::OUT_BITS{1'b1}})) begin
            return {tcs_pkg::OUT_BITS{1'b1}};
        end
        return ext[tcs_pkg::OUT_BITS-1:0];
    endfunction

    // Update counters for this byte; whitespace closes an open word
    always_comb begin
        w_close      = i_class.is_space && r_inside;
        n_byte_total = bump(r_byte_total, 1'b1);
        n_letters    = bump(r_letters, i_class.is_upper || i_class.is_lower);
        n_uppers     = bump(r_uppers, i_class.is_upper);
        n_lowers     = bump(r_lowers, i_class.is_lower);
        n_digits     = bump(r_digits, i_class.is_digit);
        n_spaces     = bump(r_spaces, i_class.is_space);
        n_others     = bump(r_others, i_class.is_other);
        n_words      = bump(r_words, w_close);
        n_inside     = !i_class.is_space;
        n_cur_len    = i_class.is_space ? '0 : bump(r_cur_len, 1'b1);
        n_best_len   = (w_close && (r_cur_len > r_best_len)) ? r_cur_len : r_best_len;
    end

    // Close a word still open at the final byte
    always_comb begin
        w_end_words = bump(n_words, n_inside);
        w_end_best  = (n_inside && (n_cur_len > n_best_len)) ? n_cur_len : n_best_len;
        o_result.total_chars      = shown(n_byte_total);
        o_result.letter_count     = shown(n_letters);
        o_result.upper_count      = shown(n_uppers);
        o_result.lower_count      = shown(n_lowers);
        o_result.digit_count      = shown(n_digits);
        o_result.space_count      = shown(n_spaces);
        o_result.other_count      = shown(n_others);
        o_result.word_count       = shown(w_end_words);
        o_result.longest_word_len = shown(w_end_best);
    end

    // Hold state; advance on each item, clear after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_byte_total <= '0;
            r_letters    <= '0;
            r_uppers     <= '0;
            r_lowers     <= '0;
            r_digits     <= '0;
            r_spaces     <= '0;
            r_others     <= '0;
            r_words      <= '0;
            r_inside     <= 1'b0;
            r_cur_len    <= '0;
            r_best_len   <= '0;
        end else if (i_fire) begin
            r_byte_total <= n_byte_total;
            r_letters    <= n_letters;
            r_uppers     <= n_uppers;
            r_lowers     <= n_lowers;
            r_digits     <= n_digits;
            r_spaces     <= n_spaces;
            r_others     <= n_others;
            r_words      <= n_words;
            r_inside     <= n_inside;
            r_cur_len    <= n_cur_len;
            r_best_len   <= n_best_len;
        end
    end

endmodule

>>> design/text_character_statistics.sv
// Text statistics counter. Feed a text one byte per item, with text_end set on its
// final byte; the block takes one byte every cycle. Bytes are classed as letter
// (upper or lower), digit, whitespace or other, and whitespace-separated words are
// counted along with the longest word length. The final byte yields one result item
// with all counts, valid once that byte has left the input register (it is counted out of
// the input register straight into the result register); every other byte yields
// none. Counters are COUNT_BITS wide and saturate, and fields show at most 65535.
// A byte that does not end a text never waits for the output; an end byte waits in
// the input register only while a previous result is still untaken. The counters
// clear after each text.
module text_character_statistics #(
    parameter int COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcs_pkg::t_tcs_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tcs_pkg::t_tcs_out o_out_data
);

    logic                r_s1_valid;
    tcs_pkg::t_tcs_in    r_s1_data;
    logic                r_out_valid;
    tcs_pkg::t_tcs_out   r_out_data;

    logic                w_s1_fire;
    logic                w_out_free;
    tcs_pkg::t_tcs_class w_class;
    tcs_pkg::t_tcs_out   w_result;

    // An end byte may only move on when the result register can take it
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_fire  = r_s1_valid && (!r_s1_data.text_end || w_out_free);
    assign o_in_ready = !r_s1_valid || w_s1_fire;

    tcs_classify u_classify (
        .i_char_byte (r_s1_data.char_byte),
        .o_class     (w_class)
    );

    tcs_counters #(
        .COUNT_BITS (COUNT_BITS)
    ) u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_s1_fire),
        .i_last   (r_s1_data.text_end),
        .i_class  (w_class),
        .o_result (w_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
    end

    // Result register: load on an end byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && r_s1_data.text_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && r_s1_data.text_end) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CNT_W          = 16;
    localparam int RANDOM_BYTES   = 1075;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    tcs_pkg::t_tcs_in  in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    tcs_pkg::t_tcs_out out_data;

    // Handshake bookkeeping
    logic     in_taken = 1'b0;
    int       send_idle_pct = 31;
    int       recv_idle_pct = 71;
    int       mismatches = 0;
    int       quiet_cycles = 0;

    // Bytes waiting to be driven and counts waiting to be seen
    tcs_pkg::t_tcs_in  pending_bytes[$];
    tcs_pkg::t_tcs_out expected_counts[$];

    // Running tally of the current text
    logic [CNT_W-1:0] n_total = '0;
    logic [CNT_W-1:0] n_letter = '0;
    logic [CNT_W-1:0] n_upper = '0;
    logic [CNT_W-1:0] n_lower = '0;
    logic [CNT_W-1:0] n_digit = '0;
    logic [CNT_W-1:0] n_space = '0;
    logic [CNT_W-1:0] n_other = '0;
    logic [CNT_W-1:0] n_words = '0;
    logic [CNT_W-1:0] cur_len = '0;
    logic [CNT_W-1:0] best_len = '0;
    logic             in_word = 1'b0;

    text_character_statistics #(
        .COUNT_BITS(CNT_W)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Clamp a counter to the width of a result field
    function automatic logic [tcs_pkg::OUT_BITS-1:0] clip(input logic [CNT_W-1:0] v);
        if (v > (2 ** tcs_pkg::OUT_BITS - 1))
            return '1;
        return v[tcs_pkg::OUT_BITS-1:0];
    endfunction

    task automatic close_word();
        if (in_word) begin
            n_words = sat_inc(n_words);
            if (cur_len > best_len)
                best_len = cur_len;
            cur_len = '0;
            in_word = 1'b0;
        end
    endtask

    // Update the tally with one accepted byte; on the end byte queue the counts
    task automatic tally_byte(input tcs_pkg::t_tcs_in item);
        logic [7:0]        b;
        logic              is_white;
        tcs_pkg::t_tcs_out res;
        b = item.char_byte;
        is_white = (b == tcs_pkg::CHR_SPACE) ||
                   (b >= tcs_pkg::CHR_TAB && b <= tcs_pkg::CHR_CR);
        n_total = sat_inc(n_total);
        if (is_white) begin
            n_space = sat_inc(n_space);
            close_word();
        end else begin
            if (b >= tcs_pkg::CHR_UP_A && b <= tcs_pkg::CHR_UP_Z) begin
                n_letter = sat_inc(n_letter);
                n_upper = sat_inc(n_upper);
            end else if (b >= tcs_pkg::CHR_LO_A && b <= tcs_pkg::CHR_LO_Z) begin
                n_letter = sat_inc(n_letter);
                n_lower = sat_inc(n_lower);
            end else if (b >= tcs_pkg::CHR_0 && b <= tcs_pkg::CHR_9) begin
                n_digit = sat_inc(n_digit);
            end else begin
                n_other = sat_inc(n_other);
            end
            cur_len = sat_inc(cur_len);
            in_word = 1'b1;
        end
        if (item.text_end) begin
            close_word();
            res.total_chars      = clip(n_total);
            res.letter_count     = clip(n_letter);
            res.upper_count      = clip(n_upper);
            res.lower_count      = clip(n_lower);
            res.digit_count      = clip(n_digit);
            res.space_count      = clip(n_space);
            res.other_count      = clip(n_other);
            res.word_count       = clip(n_words);
            res.longest_word_len = clip(best_len);
            expected_counts.push_back(res);
            // Start the next text from scratch
            n_total = '0;
            n_letter = '0;
            n_upper = '0;
            n_lower = '0;
            n_digit = '0;
            n_space = '0;
            n_other = '0;
            n_words = '0;
            cur_len = '0;
            best_len = '0;
            in_word = 1'b0;
        end
    endtask

    task automatic report(input string what);
        $display("tb_top: mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [tcs_pkg::OUT_BITS-1:0] got,
                               input logic [tcs_pkg::OUT_BITS-1:0] want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_counts(input tcs_pkg::t_tcs_out got, input tcs_pkg::t_tcs_out want);
        check_field("total_chars", got.total_chars, want.total_chars);
        check_field("letter_count", got.letter_count, want.letter_count);
        check_field("upper_count", got.upper_count, want.upper_count);
        check_field("lower_count", got.lower_count, want.lower_count);
        check_field("digit_count", got.digit_count, want.digit_count);
        check_field("space_count", got.space_count, want.space_count);
        check_field("other_count", got.other_count, want.other_count);
        check_field("word_count", got.word_count, want.word_count);
        check_field("longest_word_len", got.longest_word_len, want.longest_word_len);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        tcs_pkg::t_tcs_in item;
        item.char_byte = b;
        item.text_end = last;
        pending_bytes.push_back(item);
    endtask

    function automatic logic [7:0] pick_white();
        return ($urandom_range(0, 5) == 0) ? tcs_pkg::CHR_SPACE
                                           : 8'(tcs_pkg::CHR_TAB + $urandom_range(0, 4));
    endfunction

    // Draw a byte with a bias toward the classes that matter
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'(tcs_pkg::CHR_LO_A + $urandom_range(0, 25));
        if (r < 35)
            return 8'(tcs_pkg::CHR_UP_A + $urandom_range(0, 25));
        if (r < 47)
            return 8'(tcs_pkg::CHR_0 + $urandom_range(0, 9));
        if (r < 67)
            return pick_white();
        if (r < 77)
            return 8'(8'h21 + $urandom_range(0, 14));
        if (r < 85)
            return 8'(8'h80 + $urandom_range(0, 127));
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue random texts totalling at least nbytes bytes
    task automatic add_random_texts(input int nbytes);
        int added;
        int len;
        added = 0;
        while (added < nbytes) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                push_byte(pick_byte(), i == len - 1);
            added += len;
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Drive the input side; advance only after the current item is taken
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= pending_bytes.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check results first, then tally the byte taken at this edge
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_counts.size() == 0)
                    report("result item with no text pending");
                else
                    check_counts(out_data, expected_counts.pop_front());
            end
            if (in_valid && in_ready)
                tally_byte(in_data);
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: timeout with %0d bytes and %0d results outstanding",
                     pending_bytes.size(), expected_counts.size());
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // Hold reset low, then release it at a falling clock edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single-byte texts: one letter, one whitespace
        push_byte(tcs_pkg::CHR_UP_A, 1'b1);
        push_byte(tcs_pkg::CHR_SPACE, 1'b1);
        // Class boundaries, ending on a high byte inside an open word
        push_byte(8'h00, 1'b0);
        push_byte(8'h08, 1'b0);
        push_byte(tcs_pkg::CHR_TAB, 1'b0);
        push_byte(8'h0A, 1'b0);
        push_byte(8'h0B, 1'b0);
        push_byte(8'h0C, 1'b0);
        push_byte(tcs_pkg::CHR_CR, 1'b0);
        push_byte(8'h0E, 1'b0);
        push_byte(8'h1F, 1'b0);
        push_byte(tcs_pkg::CHR_SPACE, 1'b0);
        push_byte(8'h2F, 1'b0);
        push_byte(tcs_pkg::CHR_0, 1'b0);
        push_byte(tcs_pkg::CHR_9, 1'b0);
        push_byte(8'h3A, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(tcs_pkg::CHR_UP_A, 1'b0);
        push_byte(tcs_pkg::CHR_UP_Z, 1'b0);
        push_byte(8'h5B, 1'b0);
        push_byte(8'h60, 1'b0);
        push_byte(tcs_pkg::CHR_LO_A, 1'b0);
        push_byte(tcs_pkg::CHR_LO_Z, 1'b0);
        push_byte(8'h7B, 1'b0);
        push_byte(8'hFF, 1'b1);

        // Slow receiver
        add_random_texts(RANDOM_BYTES / 3);
        wait_drained();

        // Slow sender
        send_idle_pct = 71;
        recv_idle_pct = 31;
        add_random_texts(RANDOM_BYTES / 3);
        wait_drained();

        // Full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_texts(RANDOM_BYTES / 3);
        add_random_texts(30);
        wait_drained();

        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_counts.size() != 0)
            report($sformatf("%0d result items never arrived", expected_counts.size()));

        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
